// File: rtl/hpt_pkg.sv
`timescale 1ns / 1ps
// hpt_pkg: widths, types and helpers shared by the homogeneous point transform
// no dependencies

package hpt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;            // coordinate and coefficient width
  localparam int PW        = 2 * CW;        // product width
  localparam int NW        = PW + 2;        // row sum width, four terms
  localparam int QB        = 32;            // quotient bits produced
  localparam int QIW       = $clog2(QB);
  localparam int DW        = NW + QB + 1;   // remainder width, holds den << QB
  localparam int NCFG      = 8;
  localparam int CIW       = $clog2(NCFG);
  localparam int RW        = 64;

  localparam logic [RW-1:0] ONE_LO = RW'(64'd1 << FRAC_BITS);
  localparam logic [RW-1:0] ONE_HI = RW'(64'd1 << (FRAC_BITS + 32));

  typedef logic [NCFG-1:0][RW-1:0] mat_t;
  typedef logic [3:0][NW-1:0]      rows_t;

  typedef struct packed {
    logic [2:0]          neg;
    logic [2:0]          ovf;
    logic                wz;
    logic [NW-1:0]       den;
    logic [2:0][DW-1:0]  rem;
    logic [2:0][QB-1:0]  quo;
  } div_t;

  function automatic mat_t mat_reset();
    mat_t m;
    m    = '0;
    m[0] = ONE_LO;
    m[2] = ONE_HI;
    m[5] = ONE_LO;
    m[7] = ONE_HI;
    return m;
  endfunction

  function automatic logic [CW-1:0] coef(mat_t m, int r, int c);
    logic [RW-1:0] w;
    w = m[r * 2 + c / 2];
    return (c % 2 == 1) ? w[63:32] : w[31:0];
  endfunction

endpackage

// File: rtl/hpt_point_if.sv
`timescale 1ns / 1ps
// hpt_point_if: input point channel, valid/ready with three Q16.16 coordinates
// no dependencies

interface hpt_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// File: rtl/hpt_result_if.sv
`timescale 1ns / 1ps
// hpt_result_if: result channel, valid/ready with transformed point and flags
// no dependencies

interface hpt_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               w_zero;
  logic               overflow;

  modport source (output valid, out_x, out_y, out_z, w_zero, overflow, input ready);
  modport sink   (input valid, out_x, out_y, out_z, w_zero, overflow, output ready);
endinterface

// File: rtl/hpt_matmul.sv
`timescale 1ns / 1ps
// hpt_matmul: two register stages, twelve products then four exact row sums
// depends on hpt_pkg

module hpt_matmul import hpt_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2:0][CW-1:0]   pt_i,
  input  mat_t                 mat_i,
  output logic                 valid_o,
  output rows_t                sum_o
);

  logic signed [PW-1:0] prod_q [4][3];
  logic signed [PW-1:0] off_q  [4];
  logic                 v1_q, v2_q;
  rows_t                sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 4; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= $signed(coef(mat_i, r, c)) * $signed(pt_i[c]);
        end
        // translation column times the implicit w of one
        off_q[r] <= PW'($signed(coef(mat_i, r, 3))) <<< FRAC_BITS;
      end
    end
  end

  rows_t sum_d;
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sum_d[r] = {{(NW-PW){prod_q[r][0][PW-1]}}, prod_q[r][0]}
               + {{(NW-PW){prod_q[r][1][PW-1]}}, prod_q[r][1]}
               + {{(NW-PW){prod_q[r][2][PW-1]}}, prod_q[r][2]}
               + {{(NW-PW){off_q[r][PW-1]}}, off_q[r]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign sum_o   = sum_q;

endmodule

// File: rtl/hpt_div_prep.sv
`timescale 1ns / 1ps
// hpt_div_prep: magnitudes, signs, zero test and out-of-range precheck for the divide
// depends on hpt_pkg

module hpt_div_prep import hpt_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  logic   valid_i,
  input  rows_t  sum_i,
  output logic   valid_o,
  output div_t   div_o
);

  div_t          div_d, div_q;
  logic          valid_q;
  logic [NW-1:0] mag;
  logic [DW-1:0] den_top;

  always_comb begin
    div_d   = '0;
    div_d.den = sum_i[3][NW-1] ? NW'(-sum_i[3]) : sum_i[3];
    div_d.wz  = (sum_i[3] == '0);
    den_top   = DW'(div_d.den) << QB;
    for (int ch = 0; ch < 3; ch++) begin
      mag = sum_i[ch][NW-1] ? NW'(-sum_i[ch]) : sum_i[ch];
      div_d.neg[ch] = sum_i[ch][NW-1] ^ sum_i[3][NW-1];
      div_d.rem[ch] = DW'(mag) << FRAC_BITS;
      // quotient of 2^32 or more saturates whatever the low bits are
      div_d.ovf[ch] = (div_d.rem[ch] >= den_top);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

// File: rtl/hpt_div_step.sv
`timescale 1ns / 1ps
// hpt_div_step: one restoring divide step, one quotient bit for each of three channels
// depends on hpt_pkg

module hpt_div_step import hpt_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic [QIW-1:0] bit_i,
  input  logic           valid_i,
  input  div_t           div_i,
  output logic           valid_o,
  output div_t           div_o
);

  div_t          div_d, div_q;
  logic          valid_q;
  logic [DW-1:0] sh;

  always_comb begin
    div_d = div_i;
    sh    = DW'(div_i.den) << bit_i;
    for (int ch = 0; ch < 3; ch++) begin
      if (div_i.rem[ch] >= sh) begin
        div_d.rem[ch]        = div_i.rem[ch] - sh;
        div_d.quo[ch][bit_i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

// File: rtl/homogeneous_point_transform_top.sv
`timescale 1ns / 1ps
// homogeneous_point_transform_top: 4x4 point transform with perspective divide
// depends on hpt_pkg, hpt_point_if, hpt_result_if, hpt_matmul, hpt_div_prep, hpt_div_step
//
// usage
//   pnt_i carries one Q16.16 point (x, y, z) per transaction, treated as (x, y, z, 1).
//   res_o returns x/w, y/w, z/w in Q16.16, truncated toward zero and saturated,
//   with w_zero (outputs zero) and overflow (some quotient saturated).
//   the matrix sits in eight 64-bit registers written through cfg_we_i / cfg_idx_i /
//   cfg_data_i; write them only while no transaction is in flight.
// pipeline
//   two multiply/sum stages, one divide set-up stage, 32 restoring divide
//   stages (one quotient bit each) and one output register.
//   one transaction per cycle is accepted in steady state, unless res_o stalls.
// reset
//   clears all valid bits and loads the identity matrix.
// back-pressure
//   the whole pipeline advances together; while a result waits on res_o with
//   ready low, every stage holds and pnt_i.ready is low. nothing is dropped.

module homogeneous_point_transform_top import hpt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CIW-1:0]     cfg_idx_i,
  input  logic [RW-1:0]      cfg_data_i,
  hpt_point_if.sink          pnt_i,
  hpt_result_if.source       res_o
);

  mat_t mat_q;
  logic en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= mat_reset();
    end else if (cfg_we_i) begin
      mat_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign en          = !res_o.valid || res_o.ready;
  assign pnt_i.ready = en;

  logic [2:0][CW-1:0] pt;
  assign pt = {pnt_i.point_z, pnt_i.point_y, pnt_i.point_x};

  logic  mm_valid;
  rows_t mm_sum;

  hpt_matmul u_matmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (pnt_i.valid),
    .pt_i    (pt),
    .mat_i   (mat_q),
    .valid_o (mm_valid),
    .sum_o   (mm_sum)
  );

  logic stg_valid [QB+1];
  div_t stg_div   [QB+1];

  hpt_div_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (mm_valid),
    .sum_i   (mm_sum),
    .valid_o (stg_valid[0]),
    .div_o   (stg_div[0])
  );

  for (genvar k = 0; k < QB; k++) begin : g_div
    hpt_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .bit_i   (QIW'(QB - 1 - k)),
      .valid_i (stg_valid[k]),
      .div_i   (stg_div[k]),
      .valid_o (stg_valid[k+1]),
      .div_o   (stg_div[k+1])
    );
  end

  // sign, saturation and zero-w handling
  div_t               fin;
  logic [2:0]         sat;
  logic [2:0][31:0]   res_d;
  logic [31:0]        mag;
  logic               ovf_d;

  always_comb begin
    fin = stg_div[QB];
    for (int ch = 0; ch < 3; ch++) begin
      sat[ch] = fin.ovf[ch] || (fin.neg[ch] ? (fin.quo[ch][31] && |fin.quo[ch][30:0])
                                            : fin.quo[ch][31]);
      if (sat[ch]) begin
        mag = fin.neg[ch] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        mag = fin.quo[ch];
      end
      res_d[ch] = fin.wz ? 32'd0 : (fin.neg[ch] ? 32'(-mag) : mag);
    end
    ovf_d = !fin.wz && (|sat);
  end

  logic               rv_q;
  logic [2:0][31:0]   res_q;
  logic               wz_q, ovf_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      wz_q  <= fin.wz;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else if (en) begin
      rv_q <= stg_valid[QB];
    end
  end

  assign res_o.valid    = rv_q;
  assign res_o.out_x    = res_q[0];
  assign res_o.out_y    = res_q[1];
  assign res_o.out_z    = res_q[2];
  assign res_o.w_zero   = wz_q;
  assign res_o.overflow = ovf_q;

  a_wzero_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.w_zero |->
      res_o.out_x == 0 && res_o.out_y == 0 && res_o.out_z == 0 && !res_o.overflow)
    else $error("w_zero result not cleared");

  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pnt_i.ready |-> res_o.valid && !res_o.ready)
    else $error("input stalled without a waiting result");

  a_pipe_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(stg_valid[QB]) && $stable(mm_valid))
    else $error("pipeline moved while stalled");

endmodule

// File: sim/hpt_transform_checker.sv
`timescale 1ns / 1ps
// hpt_transform_checker: predicts transformed points from the matrix registers and
// compares them with res_o; depends on hpt_pkg, hpt_point_if and hpt_result_if

module hpt_transform_checker import hpt_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [CIW-1:0] cfg_idx_i,
  input  logic [RW-1:0]  cfg_data_i,
  hpt_point_if           pnt,
  hpt_result_if          res,
  output int             outstanding_o,
  output int             errors_o
);

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               wz;
    logic               ovf;
  } xform_t;

  logic [RW-1:0] matrix [NCFG];
  xform_t        expected_xforms [$];
  int            errors;

  function automatic logic signed [31:0] coef_of(int r, int c);
    logic [RW-1:0] word;
    word = matrix[r * 2 + c / 2];
    return (c % 2 == 1) ? word[63:32] : word[31:0];
  endfunction

  // exact row sum with 2*FRAC_BITS fraction bits
  function automatic logic signed [127:0] row_total(int r, logic signed [31:0] x,
                                                    logic signed [31:0] y,
                                                    logic signed [31:0] z);
    logic signed [127:0] acc;
    logic signed [31:0]  c0, c1, c2, c3;
    c0  = coef_of(r, 0);
    c1  = coef_of(r, 1);
    c2  = coef_of(r, 2);
    c3  = coef_of(r, 3);
    acc = c3;
    acc = acc <<< FRAC_BITS;
    acc = acc + c0 * x + c1 * y + c2 * z;
    return acc;
  endfunction

  // truncating divide, saturated to 32 bits
  function automatic logic [31:0] scaled_ratio(logic signed [127:0] n,
                                               logic signed [127:0] d, ref logic ovf);
    logic        neg;
    logic [127:0] mn, md, q, limit;
    neg   = (n < 0) != (d < 0);
    mn    = (n < 0) ? -n : n;
    md    = (d < 0) ? -d : d;
    q     = (mn << FRAC_BITS) / md;
    limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > limit) begin
      ovf = 1'b1;
      q   = limit;
    end
    return neg ? 32'(-q) : q[31:0];
  endfunction

  function automatic xform_t transform(logic signed [31:0] x, logic signed [31:0] y,
                                       logic signed [31:0] z);
    xform_t              t;
    logic signed [127:0] w;
    logic                ovf;
    ovf = 1'b0;
    w   = row_total(3, x, y, z);
    if (w == 0) begin
      t = '{0, 0, 0, 1'b1, 1'b0};
    end else begin
      t.x   = scaled_ratio(row_total(0, x, y, z), w, ovf);
      t.y   = scaled_ratio(row_total(1, x, y, z), w, ovf);
      t.z   = scaled_ratio(row_total(2, x, y, z), w, ovf);
      t.wz  = 1'b0;
      t.ovf = ovf;
    end
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    xform_t e;
    if (!rst_ni) begin
      for (int i = 0; i < NCFG; i++) matrix[i] = '0;
      matrix[0] = ONE_LO;
      matrix[2] = ONE_HI;
      matrix[5] = ONE_LO;
      matrix[7] = ONE_HI;
      expected_xforms.delete();
      errors = 0;
    end else begin
      if (pnt.valid && pnt.ready)
        expected_xforms.push_back(transform(pnt.point_x, pnt.point_y, pnt.point_z));
      if (res.valid && res.ready) begin
        if (expected_xforms.size() == 0) begin
          $error("result transaction with no expectation waiting");
          errors++;
        end else begin
          e = expected_xforms.pop_front();
          if (res.out_x !== e.x) begin
            $error("out_x mismatch: expected %0d, actual %0d", e.x, res.out_x);
            errors++;
          end
          if (res.out_y !== e.y) begin
            $error("out_y mismatch: expected %0d, actual %0d", e.y, res.out_y);
            errors++;
          end
          if (res.out_z !== e.z) begin
            $error("out_z mismatch: expected %0d, actual %0d", e.z, res.out_z);
            errors++;
          end
          if (res.w_zero !== e.wz) begin
            $error("w_zero mismatch: expected %0d, actual %0d", e.wz, res.w_zero);
            errors++;
          end
          if (res.overflow !== e.ovf) begin
            $error("overflow mismatch: expected %0d, actual %0d", e.ovf, res.overflow);
            errors++;
          end
        end
      end
      if (cfg_we_i) matrix[cfg_idx_i] = cfg_data_i;
    end
    outstanding_o <= expected_xforms.size();
    errors_o      <= errors;
  end

endmodule

// File: sim/tb_homogeneous_point_transform_top.sv
`timescale 1ns / 1ps
// tb_homogeneous_point_transform_top: drives points and matrices into the transform
// depends on hpt_pkg, the channel interfaces, the dut and hpt_transform_checker

module tb_homogeneous_point_transform_top import hpt_pkg::*;;

  localparam int STALL_LIMIT = 4000;

  logic           clk_i;
  logic           rst_ni;
  logic           cfg_we;
  logic [CIW-1:0] cfg_idx;
  logic [RW-1:0]  cfg_data;
  int             outstanding;
  int             errors;
  logic           no_idle;
  logic           hold_req;
  int             quiet_cycles;

  hpt_point_if  pnt ();
  hpt_result_if res ();

  homogeneous_point_transform_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pnt_i      (pnt),
    .res_o      (res)
  );

  hpt_transform_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .pnt           (pnt),
    .res           (res),
    .outstanding_o (outstanding),
    .errors_o      (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk_i) begin
    if ((pnt.valid && pnt.ready) || (res.valid && res.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL homogeneous_point_transform_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int gap;
    res.ready = 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (hold_req) begin
        res.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req <= 1'b0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          res.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!(res.valid && res.ready));
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0;
      3:       return 32'h0001_0000;
      4, 5:    return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      pnt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pnt.valid   <= 1'b1;
    pnt.point_x <= x;
    pnt.point_y <= y;
    pnt.point_z <= z;
    do @(posedge clk_i); while (!(pnt.valid && pnt.ready));
  endtask

  // sender pauses until every result is back, then lets the pipeline settle
  task automatic drain();
    pnt.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic load_matrix(logic [RW-1:0] m [NCFG]);
    for (int i = 0; i < NCFG; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= CIW'(i);
      cfg_data <= m[i];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [RW-1:0] m [NCFG];
    rst_ni       = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    pnt.valid    = 1'b0;
    pnt.point_x  = '0;
    pnt.point_y  = '0;
    pnt.point_z  = '0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity after reset, coordinate extremes
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0001_0000, 32'hffff_0000, 32'h1234_5678);
    send_point(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000);
    drain();

    // bottom row zero: w is zero for every point
    m = '{64'h0001_0000_0001_0000, 64'h0, 64'h0, 64'hffff_0000_0000_0000,
          64'h7fff_ffff_8000_0000, 64'h0001_0000, 64'h0, 64'h0};
    load_matrix(m);
    send_point(32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'hffff_ffff, 32'h1, 32'h7fff_ffff);
    drain();

    // tiny w against huge numerators: saturation both ways, w zero at x = 0
    m = '{64'h0000_0000_7fff_ffff, 64'h7fff_ffff_0000_0000, 64'h8000_0000_0000_0000,
          64'h0000_0000_8000_0000, 64'h0, 64'h7fff_ffff_7fff_ffff,
          64'h0000_0000_0000_0001, 64'h0};
    load_matrix(m);
    send_point(32'h1, 32'h0, 32'h0);
    send_point(32'hffff_ffff, 32'h0, 32'h0);
    send_point(32'h0, 32'h7fff_ffff, 32'h8000_0000);
    send_point(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h0001_0000, 32'h0);
    drain();

    // coefficients at their extremes, but row two holds all-ones and zero words
    m = '{64'h7fff_ffff_7fff_ffff, 64'h8000_0000_8000_0000, 64'h8000_0000_7fff_ffff,
          64'h7fff_ffff_8000_0000, 64'hffff_ffff_ffff_ffff, 64'h0,
          64'h8000_0000_8000_0000, 64'h7fff_ffff_7fff_ffff};
    load_matrix(m);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff);
    drain();

    // random matrices, each with a run of random points
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < NCFG; i++) m[i] = {rand_word(), rand_word()};
      // keep w near one in some phases so quotients stay in range
      if (ph % 3 == 1) begin
        m[6] = {32'($urandom_range(0, 512)), 32'($urandom_range(0, 512))};
        m[7] = {32'h0001_0000, 32'($urandom_range(0, 512))};
      end
      load_matrix(m);
      for (int n = 0; n < 140; n++) begin
        if (n % 40 == 0) no_idle <= ($urandom_range(0, 2) == 0);
        if (ph == 2 && n == 20) hold_req <= 1'b1;
        send_point(rand_word(), rand_word(), rand_word());
      end
      no_idle <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("PASS homogeneous_point_transform_top");
    end else begin
      $display("FAIL homogeneous_point_transform_top");
    end
    $finish;
  end

endmodule
